// ===== design/byte_budget_lru_table_macros.svh =====
// Assertion macros for the size-weighted LRU table.
// Included by the top level; depends on signals named clk and rst_n at the point of use.
`ifndef BYTE_BUDGET_LRU_TABLE_MACROS_SVH
`define BYTE_BUDGET_LRU_TABLE_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define BBLRU_ASSERT_SAME(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("bblru check failed");

// The condition must hold in the cycle after the trigger.
`define BBLRU_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("bblru check failed");

`endif

// ===== design/bblru_pkg.sv =====
// Shared types and constants of the size-weighted LRU table.
// Used by bblru_cell, bblru_ctrl and byte_budget_lru_table; depends on nothing.
`default_nettype none

package bblru_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W = 32;
    localparam int COST_W = 24;
    localparam int TOTAL_W = 28;
    localparam int USED_W = TOTAL_W + 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [TOTAL_W-1:0] BUDGET_RESET = TOTAL_W'(16777216);

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_LOOKUP = 3'd0,
        KIND_EVICT  = 3'd1,
        KIND_INSERT = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_CMP,
        CMD_DROP_MATCH,
        CMD_DROP_HEAD,
        CMD_APPEND,
        CMD_CLEAR
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FULLCHK,
        ST_APPEND,
        ST_EVICT
    } ctrl_state_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic [KEY_W-1:0]   key;
        logic [COST_W-1:0]  cost;
    } cell_bus_t;

    typedef struct packed {
        logic               valid;
        logic               match;
        logic [KEY_W-1:0]   key;
        logic [COST_W-1:0]  cost;
    } cell_state_t;

    typedef struct packed {
        logic               hit_any;
        logic [COST_W-1:0]  hit_cost;
        logic               head_valid;
        logic [KEY_W-1:0]   head_key;
        logic [COST_W-1:0]  head_cost;
        logic               tail_valid;
    } summary_t;

endpackage

`default_nettype wire

// ===== design/bblru_cell.sv =====
// One slot of the recency chain: key, cost, valid and match flag.
// Depends on bblru_pkg; takes its upper neighbor's content when a drop shifts the chain.
`default_nettype none

module bblru_cell (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire bblru_pkg::cell_bus_t   bus,
    input  wire logic                   prev_valid,
    input  wire logic                   prefix_in,
    input  wire bblru_pkg::cell_state_t upper,
    output bblru_pkg::cell_state_t      slot,
    output logic                        prefix_out
);

    logic                               valid_reg;
    logic                               valid_next;
    logic                               match_reg;
    logic                               match_next;
    logic [bblru_pkg::KEY_W-1:0]        key_reg;
    logic [bblru_pkg::KEY_W-1:0]        key_next;
    logic [bblru_pkg::COST_W-1:0]       cost_reg;
    logic [bblru_pkg::COST_W-1:0]       cost_next;

    always_comb
    begin
        valid_next = valid_reg;
        match_next = match_reg;
        key_next   = key_reg;
        cost_next  = cost_reg;
        unique case (bus.cmd)
            bblru_pkg::CMD_HOLD:
            begin
            end
            bblru_pkg::CMD_CMP:
            begin
                match_next = valid_reg && (key_reg == bus.key);
            end
            bblru_pkg::CMD_DROP_MATCH:
            begin
                if (prefix_in || match_reg)
                begin
                    valid_next = upper.valid;
                    key_next   = upper.key;
                    cost_next  = upper.cost;
                end
            end
            bblru_pkg::CMD_DROP_HEAD:
            begin
                valid_next = upper.valid;
                key_next   = upper.key;
                cost_next  = upper.cost;
            end
            bblru_pkg::CMD_APPEND:
            begin
                if (!valid_reg && prev_valid)
                begin
                    valid_next = 1'b1;
                    key_next   = bus.key;
                    cost_next  = bus.cost;
                end
            end
            bblru_pkg::CMD_CLEAR:
            begin
                valid_next = 1'b0;
                match_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        cost_reg <= cost_next;
    end

    assign slot.valid = valid_reg;
    assign slot.match = match_reg;
    assign slot.key   = key_reg;
    assign slot.cost  = cost_reg;
    assign prefix_out = prefix_in | match_reg;

endmodule

`default_nettype wire

// ===== design/bblru_ctrl.sv =====
// Sequencer of the LRU table: opcode decode, byte total, cell commands and result register.
// Depends on bblru_pkg; drives the command bus of the bblru_cell chain.
`default_nettype none

module bblru_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     opcode,
    input  wire logic [bblru_pkg::KEY_W-1:0]    entry_key,
    input  wire logic [bblru_pkg::COST_W-1:0]   entry_cost,
    input  wire logic [bblru_pkg::TOTAL_W-1:0]  budget,
    input  wire bblru_pkg::summary_t            summ,
    output bblru_pkg::cell_bus_t                bus,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [2:0]                          result_kind,
    output logic [bblru_pkg::KEY_W-1:0]         result_key,
    output logic                                hit,
    output logic [bblru_pkg::COST_W-1:0]        stored_cost,
    output logic                                retained,
    output logic [bblru_pkg::TOTAL_W-1:0]       total_bytes,
    output logic                                last
);

    bblru_pkg::ctrl_state_t                 st_reg;
    bblru_pkg::ctrl_state_t                 st_next;
    bblru_pkg::op_t                         op_reg;
    logic [bblru_pkg::KEY_W-1:0]            key_reg;
    logic [bblru_pkg::COST_W-1:0]           cost_reg;
    logic [bblru_pkg::COST_W-1:0]           cost_next;
    logic [bblru_pkg::USED_W-1:0]           used_reg;
    logic [bblru_pkg::USED_W-1:0]           used_next;

    logic                                   out_valid_reg;
    bblru_pkg::kind_t                       kind_reg;
    logic [bblru_pkg::KEY_W-1:0]            rkey_reg;
    logic                                   hit_reg;
    logic [bblru_pkg::COST_W-1:0]           scost_reg;
    logic                                   ret_reg;
    logic [bblru_pkg::TOTAL_W-1:0]          total_reg;
    logic                                   last_reg;

    logic                                   accept;
    logic                                   out_free;
    logic                                   over_budget;
    logic [bblru_pkg::USED_W-1:0]           used_less_hit;
    logic [bblru_pkg::USED_W-1:0]           used_less_head;

    logic                                   emit;
    bblru_pkg::kind_t                       e_kind;
    logic [bblru_pkg::KEY_W-1:0]            e_key;
    logic                                   e_hit;
    logic [bblru_pkg::COST_W-1:0]           e_cost;
    logic                                   e_ret;
    logic [bblru_pkg::USED_W-1:0]           e_total;
    logic [bblru_pkg::TOTAL_W-1:0]          e_total_sat;
    logic                                   e_last;

    assign accept         = in_valid && !in_stall;
    assign out_free       = !out_valid_reg || !out_stall;
    assign over_budget    = used_reg > bblru_pkg::USED_W'(budget);
    assign used_less_hit  = used_reg - bblru_pkg::USED_W'(summ.hit_cost);
    assign used_less_head = used_reg - bblru_pkg::USED_W'(summ.head_cost);
    assign e_total_sat    = (e_total > bblru_pkg::USED_W'(bblru_pkg::TOTAL_MAX))
                          ? bblru_pkg::TOTAL_MAX : e_total[bblru_pkg::TOTAL_W-1:0];

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            bblru_pkg::ST_IDLE:
            begin
                if (in_valid)
                    st_next = bblru_pkg::ST_EXEC;
            end
            bblru_pkg::ST_EXEC:
            begin
                unique case (op_reg)
                    bblru_pkg::OP_LOOKUP:
                    begin
                        if (out_free)
                            st_next = summ.hit_any ? bblru_pkg::ST_APPEND : bblru_pkg::ST_IDLE;
                    end
                    bblru_pkg::OP_INSERT:
                    begin
                        st_next = bblru_pkg::ST_FULLCHK;
                    end
                    bblru_pkg::OP_REMOVE, bblru_pkg::OP_CLEAR:
                    begin
                        if (out_free)
                            st_next = bblru_pkg::ST_IDLE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            bblru_pkg::ST_FULLCHK:
            begin
                if (!summ.tail_valid || out_free)
                    st_next = bblru_pkg::ST_APPEND;
            end
            bblru_pkg::ST_APPEND:
            begin
                st_next = (op_reg == bblru_pkg::OP_INSERT) ? bblru_pkg::ST_EVICT
                                                           : bblru_pkg::ST_IDLE;
            end
            bblru_pkg::ST_EVICT:
            begin
                if (out_free && !(over_budget && summ.head_valid))
                    st_next = bblru_pkg::ST_IDLE;
            end
            default:
            begin
                st_next = bblru_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        bus.cmd   = bblru_pkg::CMD_HOLD;
        bus.key   = key_reg;
        bus.cost  = cost_reg;
        cost_next = cost_reg;
        used_next = used_reg;
        emit      = 1'b0;
        e_kind    = bblru_pkg::KIND_LOOKUP;
        e_key     = key_reg;
        e_hit     = 1'b0;
        e_cost    = '0;
        e_ret     = 1'b0;
        e_total   = used_reg;
        e_last    = 1'b0;
        unique case (st_reg)
            bblru_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                bus.key  = entry_key;
                if (in_valid)
                    bus.cmd = bblru_pkg::CMD_CMP;
            end
            bblru_pkg::ST_EXEC:
            begin
                unique case (op_reg)
                    bblru_pkg::OP_LOOKUP:
                    begin
                        emit   = 1'b1;
                        e_kind = bblru_pkg::KIND_LOOKUP;
                        e_hit  = summ.hit_any;
                        e_cost = summ.hit_any ? summ.hit_cost : '0;
                        e_last = 1'b1;
                        if (out_free && summ.hit_any)
                        begin
                            bus.cmd   = bblru_pkg::CMD_DROP_MATCH;
                            cost_next = summ.hit_cost;
                        end
                    end
                    bblru_pkg::OP_INSERT:
                    begin
                        if (summ.hit_any)
                        begin
                            bus.cmd   = bblru_pkg::CMD_DROP_MATCH;
                            used_next = used_less_hit;
                        end
                    end
                    bblru_pkg::OP_REMOVE:
                    begin
                        emit    = 1'b1;
                        e_kind  = bblru_pkg::KIND_REMOVE;
                        e_hit   = summ.hit_any;
                        e_cost  = summ.hit_any ? summ.hit_cost : '0;
                        e_total = summ.hit_any ? used_less_hit : used_reg;
                        e_last  = 1'b1;
                        if (out_free && summ.hit_any)
                        begin
                            bus.cmd   = bblru_pkg::CMD_DROP_MATCH;
                            used_next = used_less_hit;
                        end
                    end
                    bblru_pkg::OP_CLEAR:
                    begin
                        emit    = 1'b1;
                        e_kind  = bblru_pkg::KIND_CLEAR;
                        e_total = '0;
                        e_last  = 1'b1;
                        if (out_free)
                        begin
                            bus.cmd   = bblru_pkg::CMD_CLEAR;
                            used_next = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            bblru_pkg::ST_FULLCHK:
            begin
                if (summ.tail_valid)
                begin
                    emit    = 1'b1;
                    e_kind  = bblru_pkg::KIND_EVICT;
                    e_key   = summ.head_key;
                    e_cost  = summ.head_cost;
                    e_total = used_less_head;
                    if (out_free)
                    begin
                        bus.cmd   = bblru_pkg::CMD_DROP_HEAD;
                        used_next = used_less_head;
                    end
                end
            end
            bblru_pkg::ST_APPEND:
            begin
                bus.cmd = bblru_pkg::CMD_APPEND;
                if (op_reg == bblru_pkg::OP_INSERT)
                    used_next = used_reg + bblru_pkg::USED_W'(cost_reg);
            end
            bblru_pkg::ST_EVICT:
            begin
                emit = 1'b1;
                if (over_budget && summ.head_valid)
                begin
                    e_kind  = bblru_pkg::KIND_EVICT;
                    e_key   = summ.head_key;
                    e_cost  = summ.head_cost;
                    e_total = used_less_head;
                    if (out_free)
                    begin
                        bus.cmd   = bblru_pkg::CMD_DROP_HEAD;
                        used_next = used_less_head;
                    end
                end
                else
                begin
                    e_kind = bblru_pkg::KIND_INSERT;
                    e_ret  = summ.head_valid;
                    e_last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= bblru_pkg::ST_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            used_reg <= used_next;
            if (emit && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= bblru_pkg::op_t'(opcode);
            key_reg  <= entry_key;
            cost_reg <= entry_cost;
        end
        else
        begin
            cost_reg <= cost_next;
        end
        if (emit && out_free)
        begin
            kind_reg  <= e_kind;
            rkey_reg  <= e_key;
            hit_reg   <= e_hit;
            scost_reg <= e_cost;
            ret_reg   <= e_ret;
            total_reg <= e_total_sat;
            last_reg  <= e_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign result_key  = rkey_reg;
    assign hit         = hit_reg;
    assign stored_cost = scost_reg;
    assign retained    = ret_reg;
    assign total_bytes = total_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// ===== design/byte_budget_lru_table.sv =====
// Top level of the size-weighted LRU table: budget register, cell chain and sequencer.
// Depends on bblru_pkg, bblru_cell, bblru_ctrl and byte_budget_lru_table_macros.svh.
//
// Usage: items (opcode, entry_key, entry_cost) enter on in_valid/in_stall; results leave on
// out_valid/out_stall, one transfer per result, with last set on the final result of an item.
// The budget is written through cfg_valid/cfg_ready (always ready); the user must write it
// only while the block is idle, which the block itself does not enforce. One item is worked
// at a time; in_stall is low only while the sequencer waits for an item. A lookup miss,
// remove or clear ends after the execute step; a lookup hit unlinks the entry, then re-appends
// it as most recent; an insert drops any match, drops the oldest entry of a full table, appends,
// then evicts oldest entries while over budget. A lookup, remove or clear result is registered
// in the execute step; the first insert result in the full-check step when a full table drops its
// oldest entry, else in the evict step. Each step is one broadcast command to the row of cells;
// a drop shifts every cell above the removed slot down by one in that cycle.
// A result that the receiver stalls holds in the output register, and the sequencer waits in
// its current step until the register frees, so no result is lost or repeated.
// Reset empties the table, zeroes the byte total and sets the budget to 16777216.
`default_nettype none

`include "byte_budget_lru_table_macros.svh"

module byte_budget_lru_table (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     opcode,
    input  wire logic [bblru_pkg::KEY_W-1:0]    entry_key,
    input  wire logic [bblru_pkg::COST_W-1:0]   entry_cost,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [2:0]                          result_kind,
    output logic [bblru_pkg::KEY_W-1:0]         result_key,
    output logic                                hit,
    output logic [bblru_pkg::COST_W-1:0]        stored_cost,
    output logic                                retained,
    output logic [bblru_pkg::TOTAL_W-1:0]       total_bytes,
    output logic                                last,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bblru_pkg::TOTAL_W-1:0]  byte_budget
);

    localparam bblru_pkg::cell_state_t EMPTY_SLOT = '0;

    logic [bblru_pkg::TOTAL_W-1:0]              budget_reg;
    bblru_pkg::cell_bus_t                       bus;
    bblru_pkg::cell_state_t                     slots [bblru_pkg::ENTRIES];
    logic [bblru_pkg::ENTRIES-1:0]              prefix;
    logic [bblru_pkg::ENTRIES-1:0]              valid_vec;
    logic [bblru_pkg::ENTRIES-1:0]              match_vec;
    bblru_pkg::summary_t                        summ;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            budget_reg <= bblru_pkg::BUDGET_RESET;
        else if (cfg_valid && cfg_ready)
            budget_reg <= byte_budget;
    end

    for (genvar i = 0; i < bblru_pkg::ENTRIES; i++)
    begin : g_cell
        bblru_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .bus        (bus),
            .prev_valid ((i == 0) ? 1'b1 : slots[(i == 0) ? 0 : i-1].valid),
            .prefix_in  ((i == 0) ? 1'b0 : prefix[(i == 0) ? 0 : i-1]),
            .upper      ((i == bblru_pkg::ENTRIES-1) ? EMPTY_SLOT
                         : slots[(i == bblru_pkg::ENTRIES-1) ? i : i+1]),
            .slot       (slots[i]),
            .prefix_out (prefix[i])
        );
        assign valid_vec[i] = slots[i].valid;
        assign match_vec[i] = slots[i].match;
    end

    always_comb
    begin
        summ.hit_cost = '0;
        for (int i = 0; i < bblru_pkg::ENTRIES; i++)
        begin
            summ.hit_cost = summ.hit_cost | (slots[i].match ? slots[i].cost : '0);
        end
        summ.hit_any    = prefix[bblru_pkg::ENTRIES-1];
        summ.head_valid = slots[0].valid;
        summ.head_key   = slots[0].key;
        summ.head_cost  = slots[0].cost;
        summ.tail_valid = slots[bblru_pkg::ENTRIES-1].valid;
    end

    bblru_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .entry_key   (entry_key),
        .entry_cost  (entry_cost),
        .budget      (budget_reg),
        .summ        (summ),
        .bus         (bus),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .result_key  (result_key),
        .hit         (hit),
        .stored_cost (stored_cost),
        .retained    (retained),
        .total_bytes (total_bytes),
        .last        (last)
    );

    `BBLRU_ASSERT_SAME(a_match_unique, 1'b1, $onehot0(match_vec))
    `BBLRU_ASSERT_SAME(a_valid_prefix, 1'b1, (((valid_vec >> 1) & ~valid_vec) == '0))
    `BBLRU_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)

endmodule

`default_nettype wire
